/* sv/lcfe_pkg.sv */
package lcfe_pkg;

	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_SHOW  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_ABORT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BUSY  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	localparam int COLOR_W       = 24;
	localparam int SEL_W         = 4;
	localparam int BYTES_PER_LED = 9;

	localparam logic [2:0] ONE_CODE  = 3'b110;
	localparam logic [2:0] ZERO_CODE = 3'b100;

	typedef struct packed {
		logic             byte_valid;
		logic             led_data;
		logic [SEL_W-1:0] sel;
		logic             frame_last;
		logic             busy;
		status_t          status;
	} ctl_t;

	// One line byte of an LED: sel 0..8 walks green, red, blue, three bytes each.
	function automatic logic [7:0] line_of(input logic [COLOR_W-1:0] word,
			input logic [SEL_W-1:0] sel);
		logic [7:0]  cbyte;
		logic [23:0] code;
		logic [7:0]  res;
		if (sel inside {[4'd0:4'd2]}) begin
			cbyte = word[23:16];
		end else if (sel inside {[4'd3:4'd5]}) begin
			cbyte = word[15:8];
		end else begin
			cbyte = word[7:0];
		end
		for (int i = 0; i < 8; i++) begin
			code[3*i +: 3] = cbyte[i] ? ONE_CODE : ZERO_CODE;
		end
		case (sel)
			4'd0, 4'd3, 4'd6: res = code[23:16];
			4'd1, 4'd4, 4'd7: res = code[15:8];
			default:          res = code[7:0];
		endcase
		return res;
	endfunction

endpackage

/* sv/rgb_led_chain_frame_encoder_unit.sv */
// Frame store and line encoder for a chain of RGB LEDs.
// Input channel (in_valid/in_ready) takes one word per cycle when ready: action
// selects set_color (write green/red/blue at index), show (start a frame),
// tick (emit one line byte) or abort (end the frame at once).
// Every input word yields exactly one output word on out_valid/out_ready:
// byte_valid/line_byte/frame_last for ticks, busy_res and status always.
// A frame is LED_COUNT*9 encoded bytes (each color bit as 110 or 100, MSB
// first) followed by RESET_BYTES zero bytes; frame_last marks the final one.
// Each accepted word passes the s1 control register and then the output
// register. Throughput: one word per cycle while the receiver keeps up; the
// color store has a single read port plus one register stage for read data.
// Reset: control clears at once; the color store is then zeroed in a
// clearing pass over all LED_COUNT entries, during which in_ready stays low.
// When the receiver stalls, the output register holds its word and the
// stage behind it holds one more; in_ready drops once both are full.
module rgb_led_chain_frame_encoder_unit #(
	parameter int LED_COUNT   = 64,
	parameter int RESET_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [9:0] index,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] line_byte,
	output logic       frame_last,
	output logic       busy_res,
	output logic [1:0] status
);
	import lcfe_pkg::*;

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	logic               clearing;
	logic               take_s1;
	logic               s1_valid;
	ctl_t               s1;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [COLOR_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [COLOR_W-1:0] rd_data;

	lcfe_store #(
		.DEPTH (LED_COUNT),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	lcfe_seq #(
		.LED_COUNT   (LED_COUNT),
		.RESET_BYTES (RESET_BYTES),
		.AW          (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (clearing),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.index    (index),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.take_s1  (take_s1),
		.s1_valid (s1_valid),
		.s1       (s1),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr)
	);

	lcfe_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1_valid   (s1_valid),
		.s1         (s1),
		.rd_data    (rd_data),
		.take_s1    (take_s1),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_valid (byte_valid),
		.line_byte  (line_byte),
		.frame_last (frame_last),
		.busy_res   (busy_res),
		.status     (status)
	);

endmodule

/* sv/lcfe_store.sv */
module lcfe_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          clearing,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [lcfe_pkg::COLOR_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [lcfe_pkg::COLOR_W-1:0]  rd_data
);
	import lcfe_pkg::*;

	logic [COLOR_W-1:0] mem [DEPTH];
	logic [COLOR_W-1:0] rd_q;
	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [COLOR_W-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	assign we    = clr_q || wr_en;
	assign waddr = clr_q ? clr_addr_q : wr_addr;
	assign wdata = clr_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign clearing = clr_q;
	assign rd_data  = rd_q;

	a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !wr_en && !rd_en)
		else $error("store access during clearing pass");

endmodule

/* sv/lcfe_seq.sv */
module lcfe_seq #(
	parameter int LED_COUNT   = 64,
	parameter int RESET_BYTES = 32,
	parameter int AW          = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clearing,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [9:0]                    index,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic                          take_s1,
	output logic                          s1_valid,
	output lcfe_pkg::ctl_t                s1,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [lcfe_pkg::COLOR_W-1:0]  wr_data,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr
);
	import lcfe_pkg::*;

	localparam int CW = $clog2(LED_COUNT + 1);
	localparam int TW = $clog2(RESET_BYTES + 1);

	logic             send_q, n_send;
	logic [CW-1:0]    led_q, n_led;
	logic [SEL_W-1:0] byte_q, n_byte;
	logic [TW-1:0]    tail_q, n_tail;
	logic             s1_valid_q;
	ctl_t             ctl_s1, ctl_d;
	logic             accept;
	logic             wr_c, rd_c;

	assign in_ready = !clearing && (!s1_valid_q || take_s1);
	assign accept   = in_valid && in_ready;

	always_comb begin
		n_send = send_q;
		n_led  = led_q;
		n_byte = byte_q;
		n_tail = tail_q;
		wr_c   = 1'b0;
		rd_c   = 1'b0;
		ctl_d  = '0;
		ctl_d.status = ST_OK;
		case (action_t'(action))
			ACT_SET: begin
				if ({1'b0, index} >= 11'(LED_COUNT)) begin
					ctl_d.status = ST_RANGE;
				end else if (send_q) begin
					ctl_d.status = ST_BUSY;
				end else begin
					wr_c = 1'b1;
				end
			end
			ACT_SHOW: begin
				if (send_q) begin
					ctl_d.status = ST_BUSY;
				end else begin
					n_send = 1'b1;
					n_led  = '0;
					n_byte = '0;
					n_tail = '0;
				end
			end
			ACT_TICK: begin
				if (send_q) begin
					ctl_d.byte_valid = 1'b1;
					if (led_q < CW'(LED_COUNT)) begin
						ctl_d.led_data = 1'b1;
						ctl_d.sel      = byte_q;
						rd_c           = 1'b1;
						if (byte_q == SEL_W'(BYTES_PER_LED - 1)) begin
							n_byte = '0;
							n_led  = led_q + CW'(1);
						end else begin
							n_byte = byte_q + SEL_W'(1);
						end
					end else if (tail_q == TW'(RESET_BYTES - 1)) begin
						ctl_d.frame_last = 1'b1;
						n_send = 1'b0;
						n_led  = '0;
						n_byte = '0;
						n_tail = '0;
					end else begin
						n_tail = tail_q + TW'(1);
					end
				end
			end
			default: begin
				n_send = 1'b0;
				n_led  = '0;
				n_byte = '0;
				n_tail = '0;
			end
		endcase
		ctl_d.busy = n_send;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_q     <= 1'b0;
			led_q      <= '0;
			byte_q     <= '0;
			tail_q     <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				send_q <= n_send;
				led_q  <= n_led;
				byte_q <= n_byte;
				tail_q <= n_tail;
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (take_s1) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_d;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1       = ctl_s1;
	assign wr_en    = accept && wr_c;
	assign wr_addr  = index[AW-1:0];
	assign wr_data  = {green, red, blue};
	assign rd_en    = accept && rd_c;
	assign rd_addr  = led_q[AW-1:0];

	a_idle_counters: assert property (@(posedge clk) disable iff (!arst_n)
		!send_q |-> led_q == '0 && byte_q == '0 && tail_q == '0)
		else $error("counters not cleared while idle");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= SEL_W'(BYTES_PER_LED - 1))
		else $error("byte within LED out of range");

	a_led_range: assert property (@(posedge clk) disable iff (!arst_n)
		led_q <= CW'(LED_COUNT))
		else $error("LED counter past chain length");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !send_q && !rd_en)
		else $error("store write during frame");

endmodule

/* sv/lcfe_out.sv */
module lcfe_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s1_valid,
	input  lcfe_pkg::ctl_t                s1,
	input  logic [lcfe_pkg::COLOR_W-1:0]  rd_data,
	output logic                          take_s1,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          byte_valid,
	output logic [7:0]                    line_byte,
	output logic                          frame_last,
	output logic                          busy_res,
	output logic [1:0]                    status
);
	import lcfe_pkg::*;

	logic       out_valid_q;
	logic       byte_valid_q;
	logic [7:0] line_q;
	logic       last_q;
	logic       busy_q;
	status_t    status_q;
	logic [7:0] line_d;

	assign take_s1 = !out_valid_q || out_ready;
	assign line_d  = s1.led_data ? line_of(rd_data, s1.sel) : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && s1_valid) begin
			byte_valid_q <= s1.byte_valid;
			line_q       <= line_d;
			last_q       <= s1.frame_last;
			busy_q       <= s1.busy;
			status_q     <= s1.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_valid = byte_valid_q;
	assign line_byte  = line_q;
	assign frame_last = last_q;
	assign busy_res   = busy_q;
	assign status     = status_q;

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> byte_valid_q && !busy_q && line_q == 8'd0)
		else $error("frame end word inconsistent");

endmodule

/* tb/sv/rgb_led_chain_frame_encoder_unit_tb.sv */
`timescale 1ns / 1ps

module rgb_led_chain_frame_encoder_unit_tb;
	import lcfe_pkg::*;

	localparam int LEDS        = 64;
	localparam int TAIL        = 32;
	localparam int FRAME_BYTES = LEDS * BYTES_PER_LED + TAIL;
	localparam int RAND_ITEMS  = 550;

	typedef struct {
		logic       bv;
		logic [7:0] lb;
		logic       fl;
		logic       busy;
		status_t    st;
	} line_result_t;

	class line_scoreboard;
		logic [COLOR_W-1:0] colors [LEDS];
		bit                 sending;
		int unsigned        led;
		int unsigned        nib;
		logic [7:0]         tail;
		line_result_t       pending_q [$];
		int                 errors;
		int                 frames_done;
		int                 items;

		function new();
			foreach (colors[i]) colors[i] = '0;
			sending = 0;
			led = 0;
			nib = 0;
			tail = '0;
			errors = 0;
			frames_done = 0;
			items = 0;
		endfunction

		// each color bit becomes three line bits, MSB first
		function logic [23:0] spread(logic [7:0] c);
			logic [23:0] code;
			code = '0;
			for (int i = 7; i >= 0; i--) code = {code[20:0], c[i] ? ONE_CODE : ZERO_CODE};
			return code;
		endfunction

		function void clear_frame();
			led = 0;
			nib = 0;
			tail = '0;
		endfunction

		function void note_input(action_t a, logic [9:0] idx, logic [7:0] r, logic [7:0] g,
				logic [7:0] b);
			line_result_t e;
			logic [23:0] word;
			logic [7:0]  cb;
			e.bv = 0;
			e.lb = '0;
			e.fl = 0;
			e.st = ST_OK;
			items++;
			case (a)
				ACT_SET: begin
					if (idx >= LEDS) e.st = ST_RANGE;
					else if (sending) e.st = ST_BUSY;
					else colors[idx] = {g, r, b};
				end
				ACT_SHOW: begin
					if (sending) begin
						e.st = ST_BUSY;
					end else begin
						sending = 1;
						clear_frame();
					end
				end
				ACT_TICK: begin
					if (sending) begin
						e.bv = 1;
						if (led < LEDS) begin
							word = colors[led];
							cb = 8'(word >> (16 - 8 * (nib / 3)));
							e.lb = 8'(spread(cb) >> (16 - 8 * (nib % 3)));
							nib++;
							if (nib >= BYTES_PER_LED) begin
								nib = 0;
								led++;
							end
						end else begin
							tail = tail + 8'd1;
							if (tail >= TAIL) begin
								e.fl = 1;
								sending = 0;
								frames_done++;
								clear_frame();
							end
						end
					end
				end
				default: begin
					sending = 0;
					clear_frame();
				end
			endcase
			e.busy = sending;
			pending_q.push_back(e);
		endfunction

		function void check(logic bv, logic [7:0] lb, logic fl, logic busy, logic [1:0] st);
			line_result_t e;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected word: byte_valid %b line_byte %h", $time, bv, lb);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (bv !== e.bv) begin
				$display("%0t byte_valid exp %b got %b", $time, e.bv, bv);
				errors++;
			end
			if (lb !== e.lb) begin
				$display("%0t line_byte exp %h got %h", $time, e.lb, lb);
				errors++;
			end
			if (fl !== e.fl) begin
				$display("%0t frame_last exp %b got %b", $time, e.fl, fl);
				errors++;
			end
			if (busy !== e.busy) begin
				$display("%0t busy_res exp %b got %b", $time, e.busy, busy);
				errors++;
			end
			if (st !== e.st) begin
				$display("%0t status exp %0d got %0d", $time, e.st, st);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] action;
	logic [9:0] index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       out_valid;
	logic       out_ready;
	logic       byte_valid;
	logic [7:0] line_byte;
	logic       frame_last;
	logic       busy_res;
	logic [1:0] status;

	line_scoreboard sb;

	int  burst_left;
	bit  held;
	int  stall_left;
	int  phase_left;
	bit  calm;

	rgb_led_chain_frame_encoder_unit #(
		.LED_COUNT(LEDS),
		.RESET_BYTES(TAIL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.index(index),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_valid(byte_valid),
		.line_byte(line_byte),
		.frame_last(frame_last),
		.busy_res(busy_res),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	// receiver: random stalls, with calm stretches
	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check(byte_valid, line_byte, frame_last, busy_res, status);
		if (phase_left == 0) begin
			calm = ($urandom_range(0, 2) == 0);
			phase_left = $urandom_range(20, 200);
		end else begin
			phase_left--;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
		end
	end

	task automatic push_word(input action_t a, input logic [9:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		int gap;
		in_valid <= 1'b1;
		action <= a;
		index <= idx;
		red <= r;
		green <= g;
		blue <= b;
		held = 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(a, idx, r, g, b);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			held = 0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(0, 20);
		end
	endtask

	task automatic push_noise(input action_t a);
		push_word(a, 10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic quiesce();
		if (held) begin
			in_valid <= 1'b0;
			held = 0;
		end
		do @(posedge clk); while (sb.pending_q.size() != 0);
	endtask

	task automatic run_round(input bit full);
		int nset;
		int stop_at;
		int ticks;
		int r;
		nset = $urandom_range(2, 30);
		repeat (nset) begin
			r = $urandom_range(0, 19);
			if (r == 0) push_noise(action_t'($urandom_range(0, 3)));
			else if (r == 1) push_word(ACT_SET, 10'($urandom_range(LEDS, 1023)), 8'($urandom),
				8'($urandom), 8'($urandom));
			else push_word(ACT_SET, 10'($urandom_range(0, LEDS - 1)), 8'($urandom),
				8'($urandom), 8'($urandom));
		end
		push_noise(ACT_SHOW);
		stop_at = full ? FRAME_BYTES * 2 : $urandom_range(1, FRAME_BYTES + 5);
		ticks = 0;
		while (sb.sending) begin
			r = $urandom_range(0, 49);
			if (ticks >= stop_at) begin
				push_noise(ACT_ABORT);
			end else if (r == 0) begin
				push_noise(ACT_SHOW);
			end else if (r == 1) begin
				push_noise(ACT_SET);
			end else if (r == 2) begin
				push_word(ACT_SET, 10'($urandom_range(0, LEDS - 1)), 8'($urandom),
					8'($urandom), 8'($urandom));
			end else begin
				push_noise(ACT_TICK);
				ticks++;
			end
		end
		if ($urandom_range(0, 1) == 0) push_noise(ACT_TICK);
	endtask

	initial begin
		int round;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		action = ACT_SET;
		index = '0;
		red = '0;
		green = '0;
		blue = '0;
		burst_left = 0;
		held = 0;
		stall_left = 0;
		phase_left = 0;
		calm = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		push_word(ACT_TICK, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
		push_word(ACT_ABORT, 10'h000, 8'h00, 8'h00, 8'h00);
		push_word(ACT_SET, 10'd0, 8'h00, 8'hFF, 8'hA5);
		push_word(ACT_SET, 10'(LEDS - 1), 8'hFF, 8'hFF, 8'hFF);
		push_word(ACT_SET, 10'(LEDS), 8'h12, 8'h34, 8'h56);
		push_word(ACT_SET, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
		push_word(ACT_SET, 10'd1, 8'h5A, 8'h00, 8'hFF);
		push_word(ACT_SHOW, 10'd0, 8'h00, 8'h00, 8'h00);
		push_word(ACT_SHOW, 10'd5, 8'h01, 8'h02, 8'h03);
		push_word(ACT_SET, 10'd2, 8'hC3, 8'h3C, 8'h81);
		// range check wins over busy
		push_word(ACT_SET, 10'h3FF, 8'h00, 8'h00, 8'h00);
		repeat (11) push_word(ACT_TICK, 10'd0, 8'h00, 8'h00, 8'h00);
		push_word(ACT_ABORT, 10'h155, 8'hAA, 8'h55, 8'hAA);
		push_word(ACT_TICK, 10'h2AA, 8'h55, 8'hAA, 8'h55);

		// random rounds, at least one frame run to its end
		round = 0;
		while (sb.items < 24 + RAND_ITEMS || sb.frames_done == 0) begin
			if (round == 0) begin
				quiesce();
				run_round(1);
			end else begin
				run_round(round > 1 && $urandom_range(0, 3) == 0);
			end
			round++;
		end

		quiesce();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/lcfe_pkg.sv
sv/lcfe_store.sv
sv/lcfe_seq.sv
sv/lcfe_out.sv
sv/rgb_led_chain_frame_encoder_unit.sv
tb/sv/rgb_led_chain_frame_encoder_unit_tb.sv
